// ----- rtl/core/lsc_pkg.sv -----
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types, constants and helpers for the lens shading correction block.
// ----------------------------------------------------------------------------
package lsc_pkg;

	localparam int MAX_GRID       = 16;
	localparam int MAX_DIM        = 4096;
	localparam int GAIN_FRAC_BITS = 12;
	localparam int POS_FRAC       = 12;
	localparam int NODES          = (MAX_GRID + 1) * (MAX_GRID + 1);
	localparam int MEM_DEPTH      = 4 * NODES;
	localparam int MEM_AW         = $clog2(MEM_DEPTH);
	localparam int CNT_W          = 12;
	localparam int DIM_W          = 13;
	localparam int GRID_W         = 5;
	localparam int IDX_W          = 4;
	localparam int FRAC_W         = POS_FRAC + 1;
	localparam int DIV_W          = 28;
	localparam int ACC_W          = 40;
	localparam int ACC_HALF       = ACC_W / 2;
	localparam int PROD_W         = 16 + ACC_HALF;
	localparam int SHIFT          = 2 * POS_FRAC + GAIN_FRAC_BITS;

	typedef enum logic [2:0] {
		CFG_ENABLE     = 3'd0,
		CFG_WIDTH      = 3'd1,
		CFG_HEIGHT     = 3'd2,
		CFG_GRID_COLS  = 3'd3,
		CFG_GRID_ROWS  = 3'd4,
		CFG_CFA        = 3'd5,
		CFG_PIXEL_BITS = 3'd6,
		CFG_UNUSED     = 3'd7
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_X,
		ST_WAIT_X,
		ST_DIV_Y,
		ST_WAIT_Y,
		ST_NODE_RD,
		ST_NODE_MAC,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic       load;
		logic       capture;
		logic       div_start;
		logic       div_axis_y;
		logic       lat_x;
		logic       lat_y;
		logic       node_rd;
		logic [1:0] node;
		logic       mac;
		logic       mul_lo;
		logic       mul_hi;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic passthru;
		logic div_done;
		logic out_free;
	} status_t;

	// Color channel from CFA pattern and row/column parity.
	function automatic logic [1:0] chan_of(input logic [1:0] cfa, input logic row_odd,
		input logic col_odd);
		logic [1:0] ch;
		unique case ({cfa, row_odd, col_odd})
			4'b00_00: ch = 2'd0;
			4'b00_01: ch = 2'd1;
			4'b00_10: ch = 2'd2;
			4'b00_11: ch = 2'd3;
			4'b01_00: ch = 2'd1;
			4'b01_01: ch = 2'd0;
			4'b01_10: ch = 2'd3;
			4'b01_11: ch = 2'd2;
			4'b10_00: ch = 2'd3;
			4'b10_01: ch = 2'd2;
			4'b10_10: ch = 2'd1;
			4'b10_11: ch = 2'd0;
			4'b11_00: ch = 2'd2;
			4'b11_01: ch = 2'd3;
			4'b11_10: ch = 2'd0;
			4'b11_11: ch = 2'd1;
			default:  ch = 2'd0;
		endcase
		return ch;
	endfunction

endpackage

// ----- rtl/core/bayer_lens_shading_correction.sv -----
// ----------------------------------------------------------------------------
// bayer_lens_shading_correction
// Lens shading correction of raw Bayer pixels with a bilinear gain grid.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): opcode 1 writes node_gain into the grid
// memory at node_channel/node_index and yields no output; opcode 0 is a pixel
// in raster order and yields one output transaction (pixel_out, frame_end).
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index 0..6 selects
// enable, image_width, image_height, grid_cols, grid_rows, cfa_pattern,
// pixel_bits; write only while idle.
// Sequence: a load is written in the accept step. A passthrough pixel goes from
// accept to delivery. A corrected pixel passes the accept step, two box locates
// (divider start, the quotient bits and one hand-off step each), four node reads
// from the gain memory, each a read and an accumulate, a split multiply in two
// halves and delivery. One transaction is worked at a time.
// The result sits in an output register; a new input is taken while it waits,
// and a stalled receiver only holds the block at the delivery step.
// Reset clears the config to defaults and the position counters; the gain
// memory is undefined until loaded.
// ----------------------------------------------------------------------------
module bayer_lens_shading_correction (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [15:0] pixel_in,
	input  logic [1:0]  node_channel,
	input  logic [8:0]  node_index,
	input  logic [15:0] node_gain,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] pixel_out,
	output logic        frame_end,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	lsc_pkg::cmd_t    cmd;
	lsc_pkg::status_t status;

	assign cfg_ready = 1'b1;

	lsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	lsc_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_in     (pixel_in),
		.node_channel (node_channel),
		.node_index   (node_index),
		.node_gain    (node_gain),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_out    (pixel_out),
		.frame_end    (frame_end)
	);

endmodule

// ----- rtl/core/lsc_div.sv -----
// ----------------------------------------------------------------------------
// lsc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsc_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [lsc_pkg::DIV_W-1:0]       dividend,
	input  logic [lsc_pkg::DIM_W-1:0]       divisor,
	output logic                            done,
	output logic [lsc_pkg::DIV_W-1:0]       quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [4:0]                    cnt_q;
	logic [lsc_pkg::DIM_W-1:0]     rem_q;
	logic [lsc_pkg::DIM_W-1:0]     den_q;
	logic [lsc_pkg::DIV_W-1:0]     quo_q;
	logic [lsc_pkg::DIM_W:0]       trial;
	logic                          fits;

	assign trial = {rem_q, quo_q[lsc_pkg::DIV_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(lsc_pkg::DIV_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? lsc_pkg::DIM_W'(trial - {1'b0, den_q})
			              : trial[lsc_pkg::DIM_W-1:0];
			quo_q <= {quo_q[lsc_pkg::DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/core/lsc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lsc_ctrl
// Sequencer: load, or locate, four node reads, scale, deliver, or passthru.
// ----------------------------------------------------------------------------
module lsc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              opcode,
	output logic              in_ready,
	input  lsc_pkg::status_t  status,
	output lsc_pkg::cmd_t     cmd
);

	lsc_pkg::state_t state_q, state_d;
	logic [1:0]      node_q, node_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsc_pkg::ST_IDLE;
			node_q  <= '0;
		end else begin
			state_q <= state_d;
			node_q  <= node_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		node_d   = node_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.node = node_q;
		unique case (state_q)
			lsc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				node_d   = '0;
				if (in_valid) begin
					if (opcode) begin
						cmd.load = 1'b1;
					end else begin
						cmd.capture = 1'b1;
						state_d = status.passthru ? lsc_pkg::ST_FINISH : lsc_pkg::ST_DIV_X;
					end
				end
			end
			lsc_pkg::ST_DIV_X: begin
				cmd.div_start = 1'b1;
				state_d = lsc_pkg::ST_WAIT_X;
			end
			lsc_pkg::ST_WAIT_X: begin
				if (status.div_done) begin
					cmd.lat_x = 1'b1;
					state_d = lsc_pkg::ST_DIV_Y;
				end
			end
			lsc_pkg::ST_DIV_Y: begin
				cmd.div_start  = 1'b1;
				cmd.div_axis_y = 1'b1;
				state_d = lsc_pkg::ST_WAIT_Y;
			end
			lsc_pkg::ST_WAIT_Y: begin
				if (status.div_done) begin
					cmd.lat_y = 1'b1;
					state_d = lsc_pkg::ST_NODE_RD;
				end
			end
			lsc_pkg::ST_NODE_RD: begin
				cmd.node_rd = 1'b1;
				state_d = lsc_pkg::ST_NODE_MAC;
			end
			lsc_pkg::ST_NODE_MAC: begin
				cmd.mac = 1'b1;
				node_d  = node_q + 2'd1;
				state_d = (node_q == 2'd3) ? lsc_pkg::ST_MUL_LO : lsc_pkg::ST_NODE_RD;
			end
			lsc_pkg::ST_MUL_LO: begin
				cmd.mul_lo = 1'b1;
				state_d = lsc_pkg::ST_MUL_HI;
			end
			lsc_pkg::ST_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_d = lsc_pkg::ST_FINISH;
			end
			lsc_pkg::ST_FINISH: begin
				// hold until the output register can take the result
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d = lsc_pkg::ST_IDLE;
				end
			end
			default: state_d = lsc_pkg::ST_IDLE;
		endcase
	end

endmodule

// ----- rtl/core/lsc_datapath.sv -----
// ----------------------------------------------------------------------------
// lsc_datapath
// Config registers, position counters, gain memory, interpolation and output.
// ----------------------------------------------------------------------------
module lsc_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  lsc_pkg::cmd_t     cmd,
	output lsc_pkg::status_t  status,
	input  logic              cfg_valid,
	input  logic [2:0]        cfg_index,
	input  logic [12:0]       cfg_data,
	input  logic [15:0]       pixel_in,
	input  logic [1:0]        node_channel,
	input  logic [8:0]        node_index,
	input  logic [15:0]       node_gain,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [15:0]       pixel_out,
	output logic              frame_end
);

	localparam int AW = lsc_pkg::MEM_AW;

	// configuration
	logic                          enable_q;
	logic [lsc_pkg::DIM_W-1:0]     width_q, height_q;
	logic [lsc_pkg::GRID_W-1:0]    gcols_q, grows_q;
	logic [1:0]                    cfa_q;
	logic [4:0]                    pbits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			width_q  <= 13'd1920;
			height_q <= 13'd1080;
			gcols_q  <= '0;
			grows_q  <= '0;
			cfa_q    <= '0;
			pbits_q  <= 5'd10;
		end else if (cfg_valid) begin
			unique case (lsc_pkg::cfg_idx_t'(cfg_index))
				lsc_pkg::CFG_ENABLE:     enable_q <= cfg_data[0];
				lsc_pkg::CFG_WIDTH:      width_q  <= cfg_data;
				lsc_pkg::CFG_HEIGHT:     height_q <= cfg_data;
				lsc_pkg::CFG_GRID_COLS:  gcols_q  <= cfg_data[4:0];
				lsc_pkg::CFG_GRID_ROWS:  grows_q  <= cfg_data[4:0];
				lsc_pkg::CFG_CFA:        cfa_q    <= cfg_data[1:0];
				lsc_pkg::CFG_PIXEL_BITS: pbits_q  <= cfg_data[4:0];
				lsc_pkg::CFG_UNUSED:     ;
				default:                 ;
			endcase
		end
	end

	// effective values
	logic [lsc_pkg::DIM_W-1:0]  w_eff, h_eff;
	logic [lsc_pkg::GRID_W-1:0] gc_eff, gr_eff;
	logic [4:0]                 bits_eff;

	always_comb begin
		w_eff = (width_q == '0) ? 13'd1 :
		        (width_q > 13'(lsc_pkg::MAX_DIM)) ? 13'(lsc_pkg::MAX_DIM) : width_q;
		h_eff = (height_q == '0) ? 13'd1 :
		        (height_q > 13'(lsc_pkg::MAX_DIM)) ? 13'(lsc_pkg::MAX_DIM) : height_q;
		gc_eff = (gcols_q > 5'(lsc_pkg::MAX_GRID)) ? 5'(lsc_pkg::MAX_GRID) : gcols_q;
		gr_eff = (grows_q > 5'(lsc_pkg::MAX_GRID)) ? 5'(lsc_pkg::MAX_GRID) : grows_q;
		bits_eff = (pbits_q > 5'd16) ? 5'd16 : pbits_q;
	end

	assign status.passthru = !enable_q || (gcols_q == '0) || (grows_q == '0);

	// position counters
	logic [lsc_pkg::CNT_W-1:0] col_q, row_q;
	logic                      last_col, last_row;

	assign last_col = ({1'b0, col_q} + 13'd1) >= w_eff;
	assign last_row = ({1'b0, row_q} + 13'd1) >= h_eff;

	// pixel capture
	logic [15:0] pix_q;
	logic        pass_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pix_q  <= pixel_in;
			pass_q <= status.passthru;
		end
	end

	// box locate through a shared divider
	logic [lsc_pkg::DIV_W-1:0] div_num, div_quo;
	logic [lsc_pkg::DIM_W-1:0] div_den;
	logic [15:0]               scaled;

	always_comb begin
		if (cmd.div_axis_y) begin
			scaled  = 16'(row_q * gr_eff);
			div_den = h_eff;
		end else begin
			scaled  = 16'(col_q * gc_eff);
			div_den = w_eff;
		end
		div_num = {scaled, 12'd0};
	end

	lsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (status.div_done),
		.quotient (div_quo)
	);

	logic [lsc_pkg::GRID_W-1:0]  g_sel;
	logic [lsc_pkg::IDX_W-1:0]   gm1, idx_c;
	logic [lsc_pkg::DIV_W-1:0]   fdiff;
	logic [lsc_pkg::FRAC_W-1:0]  frac_c;

	always_comb begin
		g_sel = cmd.lat_y ? gr_eff : gc_eff;
		gm1   = lsc_pkg::IDX_W'(g_sel - 5'd1);
		if (div_quo[lsc_pkg::DIV_W-1:12] > 16'(gm1)) begin
			idx_c  = gm1;
			fdiff  = div_quo - {12'd0, gm1, 12'd0};
			frac_c = (fdiff > 28'd4096) ? 13'd4096 : fdiff[12:0];
		end else begin
			idx_c  = div_quo[15:12];
			frac_c = {1'b0, div_quo[11:0]};
			fdiff  = '0;
		end
	end

	logic [lsc_pkg::IDX_W-1:0]  bx_q, by_q;
	logic [lsc_pkg::FRAC_W-1:0] fx_q, fy_q;

	always_ff @(posedge clk) begin
		if (cmd.lat_x) begin
			bx_q <= idx_c;
			fx_q <= frac_c;
		end
		if (cmd.lat_y) begin
			by_q <= idx_c;
			fy_q <= frac_c;
		end
	end

	// gain memory
	logic [15:0]   mem [lsc_pkg::MEM_DEPTH];
	logic [15:0]   rd_q;
	logic [1:0]    ch;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [8:0]    node_off;
	logic [4:0]    ny, nx, pitch;

	always_comb begin
		ch       = lsc_pkg::chan_of(cfa_q, row_q[0], col_q[0]);
		pitch    = gc_eff + 5'd1;
		ny       = {1'b0, by_q} + {4'd0, cmd.node[1]};
		nx       = {1'b0, bx_q} + {4'd0, cmd.node[0]};
		node_off = 9'(ny * pitch) + {4'd0, nx};
		rd_addr  = AW'(ch * lsc_pkg::NODES) + {2'd0, node_off};
		wr_addr  = AW'(node_channel * lsc_pkg::NODES) + {2'd0, node_index};
	end

	always_ff @(posedge clk) begin
		if (cmd.load && (node_index < 9'(lsc_pkg::NODES)))
			mem[wr_addr] <= node_gain;
		if (cmd.node_rd)
			rd_q <= mem[rd_addr];
	end

	// weights and accumulation
	logic [lsc_pkg::FRAC_W-1:0] wx, wy;
	logic [24:0]                w_q;
	logic [lsc_pkg::ACC_W-1:0]  acc_q;

	assign wx = cmd.node[0] ? fx_q : 13'd4096 - fx_q;
	assign wy = cmd.node[1] ? fy_q : 13'd4096 - fy_q;

	always_ff @(posedge clk) begin
		if (cmd.node_rd)
			w_q <= 25'(wx * wy);
		if (cmd.capture)
			acc_q <= '0;
		else if (cmd.mac)
			acc_q <= acc_q + lsc_pkg::ACC_W'(w_q * rd_q);
	end

	// pixel scale in two half products
	logic [lsc_pkg::PROD_W-1:0] p_lo_q, p_hi_q;

	always_ff @(posedge clk) begin
		if (cmd.mul_lo)
			p_lo_q <= pix_q * acc_q[lsc_pkg::ACC_HALF-1:0];
		if (cmd.mul_hi)
			p_hi_q <= pix_q * acc_q[lsc_pkg::ACC_W-1:lsc_pkg::ACC_HALF];
	end

	logic [55:0] prod;
	logic [19:0] val;
	logic [16:0] maxv;
	logic [15:0] result;

	always_comb begin
		prod   = {p_hi_q, 20'd0} + {20'd0, p_lo_q};
		val    = prod[55:lsc_pkg::SHIFT];
		maxv   = 17'((17'd1 << bits_eff) - 17'd1);
		if (pass_q)
			result = pix_q;
		else if (val > {3'd0, maxv})
			result = maxv[15:0];
		else
			result = val[15:0];
	end

	// output register and counter advance
	logic        out_valid_q;
	logic [15:0] pix_out_q;
	logic        fend_q;

	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
		end else begin
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (cmd.finish) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + 12'd1;
				end else begin
					col_q <= col_q + 12'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			pix_out_q <= result;
			fend_q    <= last_col && last_row;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pix_out_q;
	assign frame_end = fend_q;

endmodule

// ----- tb/sv/bayer_lens_shading_correction_tb.sv -----
// ----------------------------------------------------------------------------
// bayer_lens_shading_correction_tb
// Self-checking bench for the lens shading block. A behavioral model of the
// bilinear gain grid tracks every accepted transaction and predicts each
// corrected pixel and its frame end flag. The bench loads the whole grid, runs
// directed corner cases and then random frames under several register
// settings, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module bayer_lens_shading_correction_tb;
	import lsc_pkg::*;

	typedef struct {
		logic        opcode;
		logic [15:0] pixel_in;
		logic [1:0]  node_channel;
		logic [8:0]  node_index;
		logic [15:0] node_gain;
	} item_t;

	typedef struct {
		logic [15:0] pixel_out;
		logic        frame_end;
	} pixel_result_t;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 80;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        opcode;
	logic [15:0] pixel_in;
	logic [1:0]  node_channel;
	logic [8:0]  node_index;
	logic [15:0] node_gain;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] pixel_out;
	logic        frame_end;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [12:0] cfg_data;

	// shadow of the block's state
	logic [15:0]  gain_shadow [4 * NODES];
	int unsigned  pix_row;
	int unsigned  pix_col;
	logic         sh_enable;
	logic [12:0]  sh_width;
	logic [12:0]  sh_height;
	logic [4:0]   sh_grid_cols;
	logic [4:0]   sh_grid_rows;
	logic [1:0]   sh_cfa;
	logic [4:0]   sh_bits;

	int unsigned chan_map [4][4] = '{'{0, 1, 2, 3}, '{1, 0, 3, 2}, '{3, 2, 1, 0},
		'{2, 3, 0, 1}};

	pixel_result_t pending_pixels [$];

	int errors;
	int gap_max;
	int stall_max;
	int rx_hold;
	int rx_wait;
	int idle_cycles;
	int pixels_checked;
	int frames_seen;
	int loads_sent;
	int corrected_seen;

	bayer_lens_shading_correction dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.pixel_in    (pixel_in),
		.node_channel(node_channel),
		.node_index  (node_index),
		.node_gain   (node_gain),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_out   (pixel_out),
		.frame_end   (frame_end),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int unsigned clamp_size(logic [12:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return v;
	endfunction

	// box index along one axis, with the Q.12 position inside the box
	function automatic int unsigned grid_box(int unsigned pos, int unsigned grid,
		int unsigned size, output longint unsigned frac);
		longint unsigned num;
		longint unsigned box;
		num = longint'(pos) * grid;
		box = num / size;
		if (box > grid - 1)
			box = grid - 1;
		frac = ((num << POS_FRAC) / size) - (box << POS_FRAC);
		if (frac > (1 << POS_FRAC))
			frac = 1 << POS_FRAC;
		return box;
	endfunction

	function automatic void shadow_config(cfg_idx_t idx, logic [12:0] v);
		case (idx)
			CFG_ENABLE:     sh_enable = v[0];
			CFG_WIDTH:      sh_width = v;
			CFG_HEIGHT:     sh_height = v;
			CFG_GRID_COLS:  sh_grid_cols = v[4:0];
			CFG_GRID_ROWS:  sh_grid_rows = v[4:0];
			CFG_CFA:        sh_cfa = v[1:0];
			CFG_PIXEL_BITS: sh_bits = v[4:0];
			default: ;
		endcase
	endfunction

	// update the grid shadow or queue the corrected pixel for one transaction
	function automatic void shade_item(item_t it);
		int unsigned w, h, gc, gr, bx, by, ch, base, pitch, bits;
		longint unsigned one, fx, fy, g00, g10, g01, g11, acc, val, maxv;
		pixel_result_t r;
		if (it.opcode) begin
			if (it.node_index < NODES)
				gain_shadow[it.node_channel * NODES + it.node_index] = it.node_gain;
			return;
		end
		w = clamp_size(sh_width);
		h = clamp_size(sh_height);
		gc = sh_grid_cols > MAX_GRID ? MAX_GRID : sh_grid_cols;
		gr = sh_grid_rows > MAX_GRID ? MAX_GRID : sh_grid_rows;
		r.pixel_out = it.pixel_in;
		r.frame_end = 1'b0;
		if (sh_enable && gc != 0 && gr != 0) begin
			one = 1 << POS_FRAC;
			bx = grid_box(pix_col, gc, w, fx);
			by = grid_box(pix_row, gr, h, fy);
			ch = chan_map[sh_cfa][(pix_row % 2) * 2 + (pix_col % 2)];
			pitch = gc + 1;
			base = ch * NODES;
			g00 = gain_shadow[base + by * pitch + bx];
			g10 = gain_shadow[base + by * pitch + bx + 1];
			g01 = gain_shadow[base + (by + 1) * pitch + bx];
			g11 = gain_shadow[base + (by + 1) * pitch + bx + 1];
			acc = (one - fx) * (one - fy) * g00 + fx * (one - fy) * g10
				+ (one - fx) * fy * g01 + fx * fy * g11;
			val = (longint'(it.pixel_in) * acc) >> SHIFT;
			bits = sh_bits > 16 ? 16 : sh_bits;
			maxv = (longint'(1) << bits) - 1;
			if (val > maxv)
				val = maxv;
			r.pixel_out = val[15:0];
			corrected_seen++;
		end
		if (pix_col + 1 >= w) begin
			pix_col = 0;
			if (pix_row + 1 >= h) begin
				pix_row = 0;
				r.frame_end = 1'b1;
			end else begin
				pix_row++;
			end
		end else begin
			pix_col++;
		end
		pending_pixels.push_back(r);
	endfunction

	// result side: check, then draw the stall before the next transaction
	always @(posedge clk) begin
		pixel_result_t exp_r;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				pixels_checked++;
				if (frame_end)
					frames_seen++;
				if (pending_pixels.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result pixel_out=%0d frame_end=%0b",
							pixel_out, frame_end);
				end else begin
					exp_r = pending_pixels.pop_front();
					if (pixel_out !== exp_r.pixel_out || frame_end !== exp_r.frame_end) begin
						errors++;
						if (errors <= 10)
							$display("mismatch at result %0d: expected %0d/%0b, got %0d/%0b",
								pixels_checked, exp_r.pixel_out, exp_r.frame_end,
								pixel_out, frame_end);
					end
				end
				rx_wait = stall_max == 0 ? 0 : $urandom_range(0, stall_max);
			end
			if (rx_hold > 0) begin
				rx_hold--;
				out_ready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("bayer_lens_shading_correction_tb: FAIL");
			$finish;
		end
	end

	task automatic send_item(item_t it);
		int gap;
		gap = gap_max == 0 ? 0 : $urandom_range(0, gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= it.opcode;
		pixel_in     <= it.pixel_in;
		node_channel <= it.node_channel;
		node_index   <= it.node_index;
		node_gain    <= it.node_gain;
		do @(posedge clk); while (!in_ready);
		shade_item(it);
	endtask

	function automatic item_t rand_item(logic op);
		item_t it;
		it.opcode = op;
		it.pixel_in = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 1023)) : 16'($urandom);
		it.node_channel = 2'($urandom);
		it.node_index = 9'($urandom);
		it.node_gain = 16'($urandom);
		return it;
	endfunction

	task automatic send_pixel(logic [15:0] value);
		item_t it;
		it = rand_item(1'b0);
		it.pixel_in = value;
		send_item(it);
	endtask

	// wait for every expected result, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_config(logic en, logic [12:0] w, logic [12:0] h, logic [12:0] gc,
		logic [12:0] gr, logic [12:0] cfa, logic [12:0] bits);
		logic [12:0] vals [7];
		vals = '{13'(en), w, h, gc, gr, cfa, bits};
		drain();
		for (int i = 0; i < 7; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			shadow_config(cfg_idx_t'(i), vals[i]);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_reset_passthrough();
		send_pixel(16'h0000);
		send_pixel(16'hFFFF);
		send_pixel(16'h0001);
		send_pixel(16'h8000);
	endtask

	task automatic test_grid_load();
		item_t it;
		for (int c = 0; c < 4; c++) begin
			for (int n = 0; n < NODES; n++) begin
				it = rand_item(1'b1);
				it.node_channel = c[1:0];
				it.node_index = n[8:0];
				case ($urandom_range(0, 7))
					0: it.node_gain = 16'h0000;
					1: it.node_gain = 16'hFFFF;
					2: it.node_gain = 16'h1000;
					default: it.node_gain = 16'($urandom_range(16'h0800, 16'h3000));
				endcase
				send_item(it);
				loads_sent++;
			end
		end
		// indexes past the node grid are dropped
		it = rand_item(1'b1);
		it.node_index = 9'(NODES);
		send_item(it);
		it.node_index = 9'h1FF;
		send_item(it);
	endtask

	task automatic test_directed();
		// counters sit past the new width: the next pixel ends the row
		apply_config(1'b1, 13'd3, 13'd2, 13'd2, 13'd1, 13'd0, 13'd16);
		send_pixel(16'hFFFF);
		send_pixel(16'h0000);
		send_pixel(16'hFFFF);
		send_pixel(16'h1234);
		send_pixel(16'hFFFF);
		send_pixel(16'h8001);
		apply_config(1'b1, 13'd4, 13'd3, 13'd16, 13'd16, 13'd1, 13'd0);
		send_pixel(16'hFFFF);
		send_pixel(16'h7FFF);
		apply_config(1'b1, 13'd0, 13'd0, 13'd31, 13'd31, 13'd2, 13'd31);
		send_pixel(16'hFFFF);
		send_pixel(16'h00FF);
		apply_config(1'b1, 13'd8191, 13'd8191, 13'd1, 13'd17, 13'd3, 13'd1);
		send_pixel(16'hFFFF);
		send_pixel(16'h0003);
		apply_config(1'b0, 13'd5, 13'd2, 13'd4, 13'd4, 13'd0, 13'd8);
		send_pixel(16'hFFFF);
		send_pixel(16'h0001);
		apply_config(1'b1, 13'd5, 13'd2, 13'd0, 13'd4, 13'd0, 13'd8);
		send_pixel(16'hFFFF);
		apply_config(1'b1, 13'd5, 13'd2, 13'd4, 13'd0, 13'd0, 13'd8);
		send_pixel(16'hFFFF);
		apply_config(1'b1, 13'd4096, 13'd4096, 13'd16, 13'd16, 13'd0, 13'd16);
		send_pixel(16'hFFFF);
		send_pixel(16'h0000);
	endtask

	task automatic test_random_frames(int target);
		int sent;
		int n;
		logic [12:0] w, h, gc, gr;
		sent = 0;
		while (sent < target) begin
			w = $urandom_range(0, 9) == 0 ? 13'($urandom) : 13'($urandom_range(1, 24));
			h = $urandom_range(0, 9) == 0 ? 13'($urandom) : 13'($urandom_range(1, 8));
			gc = $urandom_range(0, 7) == 0 ? 13'($urandom_range(0, 31))
				: 13'($urandom_range(1, 16));
			gr = $urandom_range(0, 7) == 0 ? 13'($urandom_range(0, 31))
				: 13'($urandom_range(1, 16));
			apply_config($urandom_range(0, 7) != 0, w, h, gc, gr,
				13'($urandom_range(0, 3)), 13'($urandom_range(0, 31)));
			gap_max = $urandom_range(0, 2) == 0 ? 0 : 16;
			stall_max = $urandom_range(0, 2) == 0 ? 0 : 16;
			n = $urandom_range(20, 80);
			repeat (n) begin
				send_item(rand_item($urandom_range(0, 9) == 0));
				sent++;
			end
		end
		gap_max = 16;
		stall_max = 16;
	endtask

	task automatic test_output_backpressure();
		apply_config(1'b1, 13'd6, 13'd4, 13'd3, 13'd2, 13'd1, 13'd12);
		gap_max = 0;
		rx_hold = 400;
		repeat (16) send_item(rand_item(1'b0));
		gap_max = 16;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = 1'b0;
		pixel_in = '0;
		node_channel = '0;
		node_index = '0;
		node_gain = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_ENABLE;
		cfg_data = '0;
		errors = 0;
		gap_max = 16;
		stall_max = 16;
		rx_hold = 0;
		rx_wait = 0;
		idle_cycles = 0;
		pixels_checked = 0;
		frames_seen = 0;
		loads_sent = 0;
		corrected_seen = 0;
		pix_row = 0;
		pix_col = 0;
		sh_enable = 1'b0;
		sh_width = 13'd1920;
		sh_height = 13'd1080;
		sh_grid_cols = '0;
		sh_grid_rows = '0;
		sh_cfa = '0;
		sh_bits = 5'd10;
		foreach (gain_shadow[i])
			gain_shadow[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_passthrough();
		test_grid_load();
		test_directed();
		test_random_frames(800);
		test_output_backpressure();
		drain();

		$display("covered %0d grid loads, %0d pixels checked (%0d corrected), %0d frame ends",
			loads_sent, pixels_checked, corrected_seen, frames_seen);
		$display("random register settings, all CFA patterns, passthrough and stall phases");
		if (errors == 0)
			$display("bayer_lens_shading_correction_tb: PASS");
		else
			$display("bayer_lens_shading_correction_tb: FAIL");
		$finish;
	end

endmodule
